@@ hw/rtl/tesp_pkg.sv @@
package tesp_pkg;

	typedef enum logic [2:0] {
		MODE_GROUND  = 3'd0,
		MODE_ESCAPE  = 3'd1,
		MODE_CSI     = 3'd2,
		MODE_OSC     = 3'd3,
		MODE_OSC_ESC = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_TEXT      = 3'd0,
		KIND_CONTROL   = 3'd1,
		KIND_ESCAPE    = 3'd2,
		KIND_CSI_PARAM = 3'd3,
		KIND_CSI_FINAL = 3'd4,
		KIND_OSC_BYTE  = 3'd5,
		KIND_OSC_END   = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_READ = 2'd1,
		SEQ_EMIT = 2'd2,
		SEQ_END  = 2'd3
	} seq_state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       last;
	} event_t;

	localparam logic [7:0] BYTE_ESC       = 8'h1B;
	localparam logic [7:0] BYTE_BEL       = 8'h07;
	localparam logic [7:0] BYTE_BSLASH    = 8'h5C;
	localparam logic [7:0] BYTE_LBRACKET  = 8'h5B;
	localparam logic [7:0] BYTE_RBRACKET  = 8'h5D;
	localparam logic [7:0] BYTE_CTRL_END  = 8'h20;
	localparam logic [7:0] BYTE_FINAL_LO  = 8'h40;
	localparam logic [7:0] BYTE_FINAL_HI  = 8'h7E;

endpackage

@@ hw/rtl/tesp_byte_if.sv @@
interface tesp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

@@ hw/rtl/tesp_event_if.sv @@
interface tesp_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [7:0] event_byte;
	logic       run_last;

	modport source (output valid, output event_kind, output event_byte, output run_last,
		input ready);
	modport sink (input valid, input event_kind, input event_byte, input run_last,
		output ready);
endinterface

@@ hw/rtl/tesp_mem.sv @@
module tesp_mem #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/tesp_out_reg.sv @@
module tesp_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  tesp_pkg::event_t     ev,
	output logic                 can_load,
	tesp_event_if.source         events
);

	logic             valid_q;
	tesp_pkg::event_t ev_q;

	assign can_load = !valid_q || events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && can_load) begin
			valid_q <= 1'b1;
		end else if (events.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			ev_q <= ev;
		end
	end

	assign events.valid      = valid_q;
	assign events.event_kind = ev_q.kind;
	assign events.event_byte = ev_q.data;
	assign events.run_last   = ev_q.last;

endmodule

@@ hw/rtl/terminal_escape_sequence_parser_core.sv @@
// A text, control or escape event is offered in the cycle after its byte transfer.
// Throughput: 1 byte per cycle while bytes are buffered or reported directly and the output is not stalled.
// A sequence end with N buffered bytes holds off input until its run is out: each byte
// is read from the buffer (registered RAM read), then loaded into the output register.
// Reset: mode returns to ground, counts clear, output register empties; buffers keep contents.
module terminal_escape_sequence_parser_core #(
	parameter int CSI_DEPTH = 32,
	parameter int OSC_DEPTH = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	tesp_byte_if.sink    host,
	tesp_event_if.source events
);

	localparam int CSI_AW = (CSI_DEPTH > 1) ? $clog2(CSI_DEPTH) : 1;
	localparam int OSC_AW = (OSC_DEPTH > 1) ? $clog2(OSC_DEPTH) : 1;
	localparam int CSI_CW = $clog2(CSI_DEPTH + 1);
	localparam int OSC_CW = $clog2(OSC_DEPTH + 1);
	localparam int RUN_CW = (CSI_CW > OSC_CW) ? CSI_CW : OSC_CW;

	tesp_pkg::mode_t      mode_q, mode_d;
	tesp_pkg::seq_state_t seq_q, seq_d;
	logic [CSI_CW-1:0]    csi_cnt_q, csi_cnt_d;
	logic [OSC_CW-1:0]    osc_cnt_q, osc_cnt_d;
	logic [RUN_CW-1:0]    run_len_q, run_len_d;
	logic [RUN_CW-1:0]    run_idx_q, run_idx_d;
	logic [RUN_CW-1:0]    run_idx_inc;
	logic                 run_osc_q, run_osc_d;
	logic [7:0]           end_byte_q, end_byte_d;

	logic                 can_load;
	logic                 ev_load;
	tesp_pkg::event_t     ev;
	logic                 accept;
	logic [7:0]           b;
	logic                 csi_we, osc_we, csi_re, osc_re;
	logic [7:0]           csi_rdata, osc_rdata;

	assign b           = host.in_byte;
	assign host.ready  = (seq_q == tesp_pkg::SEQ_IDLE) && can_load;
	assign accept      = host.valid && host.ready;
	assign run_idx_inc = run_idx_q + 1'b1;

	tesp_mem #(.DEPTH(CSI_DEPTH), .AW(CSI_AW)) u_csi_mem (
		.clk   (clk),
		.we    (csi_we),
		.waddr (csi_cnt_q[CSI_AW-1:0]),
		.wdata (b),
		.re    (csi_re),
		.raddr (run_idx_q[CSI_AW-1:0]),
		.rdata (csi_rdata)
	);

	tesp_mem #(.DEPTH(OSC_DEPTH), .AW(OSC_AW)) u_osc_mem (
		.clk   (clk),
		.we    (osc_we),
		.waddr (osc_cnt_q[OSC_AW-1:0]),
		.wdata (b),
		.re    (osc_re),
		.raddr (run_idx_q[OSC_AW-1:0]),
		.rdata (osc_rdata)
	);

	tesp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ev_load),
		.ev       (ev),
		.can_load (can_load),
		.events   (events)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= tesp_pkg::MODE_GROUND;
			seq_q     <= tesp_pkg::SEQ_IDLE;
			csi_cnt_q <= '0;
			osc_cnt_q <= '0;
			run_len_q <= '0;
			run_idx_q <= '0;
			run_osc_q <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			seq_q     <= seq_d;
			csi_cnt_q <= csi_cnt_d;
			osc_cnt_q <= osc_cnt_d;
			run_len_q <= run_len_d;
			run_idx_q <= run_idx_d;
			run_osc_q <= run_osc_d;
		end
	end

	always_ff @(posedge clk) begin
		end_byte_q <= end_byte_d;
	end

	always_comb begin
		mode_d     = mode_q;
		seq_d      = seq_q;
		csi_cnt_d  = csi_cnt_q;
		osc_cnt_d  = osc_cnt_q;
		run_len_d  = run_len_q;
		run_idx_d  = run_idx_q;
		run_osc_d  = run_osc_q;
		end_byte_d = end_byte_q;
		csi_we     = 1'b0;
		osc_we     = 1'b0;
		csi_re     = 1'b0;
		osc_re     = 1'b0;
		ev_load    = 1'b0;
		ev         = '{kind: tesp_pkg::KIND_TEXT, data: b, last: 1'b1};

		case (seq_q)
			tesp_pkg::SEQ_IDLE: begin
				if (accept) begin
					case (mode_q)
						tesp_pkg::MODE_ESCAPE: begin
							if (b == tesp_pkg::BYTE_LBRACKET) begin
								csi_cnt_d = '0;
								mode_d    = tesp_pkg::MODE_CSI;
							end else if (b == tesp_pkg::BYTE_RBRACKET) begin
								osc_cnt_d = '0;
								mode_d    = tesp_pkg::MODE_OSC;
							end else begin
								ev_load = 1'b1;
								ev.kind = tesp_pkg::KIND_ESCAPE;
								mode_d  = tesp_pkg::MODE_GROUND;
							end
						end
						tesp_pkg::MODE_CSI: begin
							if (b >= tesp_pkg::BYTE_FINAL_LO && b <= tesp_pkg::BYTE_FINAL_HI) begin
								mode_d     = tesp_pkg::MODE_GROUND;
								run_osc_d  = 1'b0;
								run_len_d  = RUN_CW'(csi_cnt_q);
								run_idx_d  = '0;
								end_byte_d = b;
								seq_d      = (csi_cnt_q == '0) ? tesp_pkg::SEQ_END
									: tesp_pkg::SEQ_READ;
							end else if (csi_cnt_q >= CSI_CW'(CSI_DEPTH)) begin
								csi_cnt_d = '0;
								mode_d    = tesp_pkg::MODE_GROUND;
							end else begin
								csi_we    = 1'b1;
								csi_cnt_d = csi_cnt_q + 1'b1;
							end
						end
						tesp_pkg::MODE_OSC: begin
							if (b == tesp_pkg::BYTE_BEL) begin
								mode_d     = tesp_pkg::MODE_GROUND;
								run_osc_d  = 1'b1;
								run_len_d  = RUN_CW'(osc_cnt_q);
								run_idx_d  = '0;
								end_byte_d = b;
								seq_d      = (osc_cnt_q == '0) ? tesp_pkg::SEQ_END
									: tesp_pkg::SEQ_READ;
							end else if (b == tesp_pkg::BYTE_ESC) begin
								mode_d = tesp_pkg::MODE_OSC_ESC;
							end else if (osc_cnt_q >= OSC_CW'(OSC_DEPTH)) begin
								osc_cnt_d = '0;
								mode_d    = tesp_pkg::MODE_GROUND;
							end else begin
								osc_we    = 1'b1;
								osc_cnt_d = osc_cnt_q + 1'b1;
							end
						end
						tesp_pkg::MODE_OSC_ESC: begin
							mode_d = tesp_pkg::MODE_GROUND;
							if (b == tesp_pkg::BYTE_BSLASH) begin
								run_osc_d  = 1'b1;
								run_len_d  = RUN_CW'(osc_cnt_q);
								run_idx_d  = '0;
								end_byte_d = b;
								seq_d      = (osc_cnt_q == '0) ? tesp_pkg::SEQ_END
									: tesp_pkg::SEQ_READ;
							end
						end
						default: begin
							mode_d = tesp_pkg::MODE_GROUND;
							if (b == tesp_pkg::BYTE_ESC) begin
								mode_d = tesp_pkg::MODE_ESCAPE;
							end else if (b < tesp_pkg::BYTE_CTRL_END) begin
								ev_load = 1'b1;
								ev.kind = tesp_pkg::KIND_CONTROL;
							end else begin
								ev_load = 1'b1;
								ev.kind = tesp_pkg::KIND_TEXT;
							end
						end
					endcase
				end
			end
			tesp_pkg::SEQ_READ: begin
				csi_re = !run_osc_q;
				osc_re = run_osc_q;
				seq_d  = tesp_pkg::SEQ_EMIT;
			end
			tesp_pkg::SEQ_EMIT: begin
				ev_load = 1'b1;
				ev.kind = run_osc_q ? tesp_pkg::KIND_OSC_BYTE : tesp_pkg::KIND_CSI_PARAM;
				ev.data = run_osc_q ? osc_rdata : csi_rdata;
				ev.last = 1'b0;
				if (can_load) begin
					run_idx_d = run_idx_inc;
					seq_d     = (run_idx_inc == run_len_q) ? tesp_pkg::SEQ_END
						: tesp_pkg::SEQ_READ;
				end
			end
			tesp_pkg::SEQ_END: begin
				ev_load = 1'b1;
				ev.kind = run_osc_q ? tesp_pkg::KIND_OSC_END : tesp_pkg::KIND_CSI_FINAL;
				ev.data = end_byte_q;
				ev.last = 1'b1;
				if (can_load) begin
					seq_d = tesp_pkg::SEQ_IDLE;
				end
			end
			default: begin
				seq_d = tesp_pkg::SEQ_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != tesp_pkg::SEQ_IDLE) |-> !(csi_we || osc_we))
		else $error("buffer written during run readout");

	a_csi_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		csi_cnt_q <= CSI_CW'(CSI_DEPTH))
		else $error("csi count above depth");

	a_osc_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		osc_cnt_q <= OSC_CW'(OSC_DEPTH))
		else $error("osc count above depth");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == tesp_pkg::SEQ_READ || seq_q == tesp_pkg::SEQ_EMIT)
		|-> (run_idx_q < run_len_q))
		else $error("run index past run length");

	a_emit_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == tesp_pkg::SEQ_EMIT) |-> ($past(seq_q) == tesp_pkg::SEQ_READ
		|| $past(seq_q) == tesp_pkg::SEQ_EMIT))
		else $error("emit without buffer read");
`endif

endmodule

@@ dv/terminal_escape_sequence_parser_core_test.sv @@
module terminal_escape_sequence_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tesp_pkg::*;

	localparam int CSI_DEPTH    = 32;
	localparam int OSC_DEPTH    = 48;
	localparam int RANDOM_ITEMS = 10;
	localparam int STALL_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 2 * OSC_DEPTH + 8;

	logic clk;
	logic arst_n;

	tesp_byte_if  host_if ();
	tesp_event_if event_if ();

	terminal_escape_sequence_parser_core #(
		.CSI_DEPTH (CSI_DEPTH),
		.OSC_DEPTH (OSC_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.host   (host_if),
		.events (event_if)
	);

	// predicted parser state
	mode_t      pred_mode;
	logic [7:0] csi_buf [CSI_DEPTH];
	int         csi_len;
	logic [7:0] osc_buf [OSC_DEPTH];
	int         osc_len;

	event_t pending_events [$];
	logic   idle_on;
	int     errors;
	int     bytes_sent;
	int     events_seen;
	int     kind_seen [7];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void push_event(input kind_t kind, input logic [7:0] data,
		input logic last);
		event_t ev;
		ev.kind = kind;
		ev.data = data;
		ev.last = last;
		pending_events = {pending_events, ev};
	endfunction

	function automatic void push_csi_run(input logic [7:0] term);
		for (int i = 0; i < csi_len; i++)
			push_event(KIND_CSI_PARAM, csi_buf[i], 1'b0);
		push_event(KIND_CSI_FINAL, term, 1'b1);
	endfunction

	function automatic void push_osc_run(input logic [7:0] term);
		for (int i = 0; i < osc_len; i++)
			push_event(KIND_OSC_BYTE, osc_buf[i], 1'b0);
		push_event(KIND_OSC_END, term, 1'b1);
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		case (pred_mode)
			MODE_ESCAPE: begin
				if (b == BYTE_LBRACKET) begin
					csi_len = 0;
					pred_mode = MODE_CSI;
				end else if (b == BYTE_RBRACKET) begin
					osc_len = 0;
					pred_mode = MODE_OSC;
				end else begin
					push_event(KIND_ESCAPE, b, 1'b1);
					pred_mode = MODE_GROUND;
				end
			end
			MODE_CSI: begin
				if (b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI) begin
					push_csi_run(b);
					pred_mode = MODE_GROUND;
				end else if (csi_len >= CSI_DEPTH) begin
					csi_len = 0;
					pred_mode = MODE_GROUND;
				end else begin
					csi_buf[csi_len] = b;
					csi_len++;
				end
			end
			MODE_OSC: begin
				if (b == BYTE_BEL) begin
					push_osc_run(b);
					pred_mode = MODE_GROUND;
				end else if (b == BYTE_ESC) begin
					pred_mode = MODE_OSC_ESC;
				end else if (osc_len >= OSC_DEPTH) begin
					osc_len = 0;
					pred_mode = MODE_GROUND;
				end else begin
					osc_buf[osc_len] = b;
					osc_len++;
				end
			end
			MODE_OSC_ESC: begin
				if (b == BYTE_BSLASH)
					push_osc_run(b);
				pred_mode = MODE_GROUND;
			end
			default: begin
				pred_mode = MODE_GROUND;
				if (b == BYTE_ESC)
					pred_mode = MODE_ESCAPE;
				else if (b < BYTE_CTRL_END)
					push_event(KIND_CONTROL, b, 1'b1);
				else
					push_event(KIND_TEXT, b, 1'b1);
			end
		endcase
	endfunction

	function automatic logic [7:0] csi_param_byte();
		logic [7:0] b;
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(8'h30, 8'h3F));
		do
			b = 8'($urandom_range(0, 255));
		while (b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI);
		return b;
	endfunction

	function automatic logic [7:0] osc_text_byte();
		logic [7:0] b;
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(8'h20, 8'h7E));
		do
			b = 8'($urandom_range(0, 255));
		while (b == BYTE_BEL || b == BYTE_ESC);
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			host_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		host_if.valid <= 1'b1;
		host_if.in_byte <= b;
		do
			@(posedge clk);
		while (!host_if.ready);
		parse_byte(b);
		bytes_sent++;
	endtask

	task automatic drain_results();
		host_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_events.size() != 0);
	endtask

	task automatic send_csi_body(input int n);
		send_byte(BYTE_ESC);
		send_byte(BYTE_LBRACKET);
		repeat (n) send_byte(csi_param_byte());
	endtask

	task automatic send_osc_body(input int n);
		send_byte(BYTE_ESC);
		send_byte(BYTE_RBRACKET);
		repeat (n) send_byte(osc_text_byte());
	endtask

	task automatic check_event();
		event_t want;
		events_seen++;
		if (event_if.event_kind <= KIND_OSC_END)
			kind_seen[event_if.event_kind]++;
		if (pending_events.size() == 0) begin
			$display("%0t: unexpected event, expected none, actual kind %0d byte %02h last %0d",
				$time, event_if.event_kind, event_if.event_byte, event_if.run_last);
			errors++;
		end else begin
			want = pending_events.pop_front();
			if (event_if.event_kind !== want.kind) begin
				$display("%0t: event_kind expected %0d actual %0d",
					$time, want.kind, event_if.event_kind);
				errors++;
			end
			if (event_if.event_byte !== want.data) begin
				$display("%0t: event_byte expected %02h actual %02h",
					$time, want.data, event_if.event_byte);
				errors++;
			end
			if (event_if.run_last !== want.last) begin
				$display("%0t: run_last expected %0d actual %0d",
					$time, want.last, event_if.run_last);
				errors++;
			end
		end
	endtask

	initial begin : event_sink
		int stall;
		event_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				event_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			event_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!event_if.valid);
			check_event();
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((host_if.valid && host_if.ready) || (event_if.valid && event_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	task automatic test_ground_bytes();
		send_byte(8'h00);
		send_byte(8'h1F);
		send_byte(8'h20);
		send_byte(8'hFF);
	endtask

	task automatic test_escape();
		send_byte(BYTE_ESC);
		send_byte(8'h41);
		send_byte(BYTE_ESC);
		send_byte(BYTE_ESC);
	endtask

	task automatic test_csi();
		// params include ESC, a control and a high byte
		send_byte(BYTE_ESC);
		send_byte(BYTE_LBRACKET);
		send_byte(8'h31);
		send_byte(BYTE_ESC);
		send_byte(8'h05);
		send_byte(8'hFF);
		send_byte(BYTE_FINAL_HI);
		// empty run
		send_byte(BYTE_ESC);
		send_byte(BYTE_LBRACKET);
		send_byte(BYTE_FINAL_LO);
	endtask

	task automatic test_osc();
		send_byte(BYTE_ESC);
		send_byte(BYTE_RBRACKET);
		send_byte(BYTE_BEL);
		send_byte(BYTE_ESC);
		send_byte(BYTE_RBRACKET);
		send_byte(8'h78);
		send_byte(BYTE_ESC);
		send_byte(BYTE_BSLASH);
		// ESC then a non-backslash is swallowed
		send_byte(BYTE_ESC);
		send_byte(BYTE_RBRACKET);
		send_byte(BYTE_ESC);
		send_byte(8'h71);
	endtask

	task automatic test_buffer_limits();
		idle_on = 1'b0;
		send_csi_body(CSI_DEPTH);
		send_byte(8'($urandom_range(BYTE_FINAL_LO, BYTE_FINAL_HI)));
		send_csi_body(CSI_DEPTH);
		send_byte(csi_param_byte());
		drain_results();
		idle_on = 1'b1;
		send_osc_body(OSC_DEPTH);
		send_byte(BYTE_BEL);
		send_osc_body(OSC_DEPTH);
		send_byte(osc_text_byte());
		drain_results();
	endtask

	task automatic test_random_streams();
		int start;
		int pick;
		int len;
		int seqs;
		logic [7:0] b;
		start = bytes_sent;
		seqs = 0;
		while (bytes_sent - start < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				repeat ($urandom_range(1, 4)) begin
					do
						b = 8'($urandom_range(0, 255));
					while (b == BYTE_ESC);
					send_byte(b);
				end
			end else if (pick < 35) begin
				send_byte(BYTE_ESC);
				send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 60) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, CSI_DEPTH)
					: $urandom_range(0, 6);
				send_csi_body(len);
				send_byte(8'($urandom_range(BYTE_FINAL_LO, BYTE_FINAL_HI)));
			end else if (pick < 85) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, OSC_DEPTH)
					: $urandom_range(0, 6);
				send_osc_body(len);
				case ($urandom_range(0, 5))
					0, 1, 2: send_byte(BYTE_BEL);
					3, 4: begin
						send_byte(BYTE_ESC);
						send_byte(BYTE_BSLASH);
					end
					default: begin
						send_byte(BYTE_ESC);
						do
							b = 8'($urandom_range(0, 255));
						while (b == BYTE_BSLASH);
						send_byte(b);
					end
				endcase
			end else begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			end
			seqs++;
			if (seqs % 12 == 0)
				drain_results();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		host_if.valid <= 1'b0;
		host_if.in_byte <= 8'h00;
		pred_mode = MODE_GROUND;
		csi_len = 0;
		osc_len = 0;
		idle_on = 1'b1;
		errors = 0;
		bytes_sent = 0;
		events_seen = 0;
		foreach (kind_seen[k]) kind_seen[k] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ground_bytes();
		test_escape();
		test_csi();
		test_osc();
		test_buffer_limits();
		test_random_streams();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_events.size() != 0) begin
			$display("%0t: %0d events expected, actual none", $time, pending_events.size());
			errors++;
		end

		$display("covered %0d host bytes, %0d events: text %0d control %0d escape %0d",
			bytes_sent, events_seen, kind_seen[KIND_TEXT], kind_seen[KIND_CONTROL],
			kind_seen[KIND_ESCAPE]);
		$display("csi runs %0d, osc runs %0d, full and overflowing buffers included",
			kind_seen[KIND_CSI_FINAL], kind_seen[KIND_OSC_END]);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/tesp_pkg.sv
hw/rtl/tesp_byte_if.sv
hw/rtl/tesp_event_if.sv
hw/rtl/tesp_mem.sv
hw/rtl/tesp_out_reg.sv
hw/rtl/terminal_escape_sequence_parser_core.sv
dv/terminal_escape_sequence_parser_core_test.sv
